[hw/rtl/htfc_pkg.sv]
package htfc_pkg;

  // CRC-8 over a two-byte word, MSB first, no final xor.
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Scale factors: 1750 and 1000 tenths, each with 8 fraction bits.
  localparam logic [18:0] TEMP_SCALE  = 19'd448000;
  localparam logic [17:0] HUM_SCALE   = 18'd256000;
  localparam logic [19:0] TEMP_OFFSET = 20'sd115200;

  // Largest samples in Q.8 tenths, used to size the running sums.
  localparam int TEMP_SAMPLE_MAX = 332800;
  localparam int HUM_SAMPLE_MAX  = 256000;

  localparam int DEFAULT_WINDOW_DEPTH = 8;

  localparam logic signed [11:0] TEMP_HIGH_RESET = 12'sd850;
  localparam logic signed [11:0] TEMP_LOW_RESET  = -12'sd400;
  localparam logic [9:0]         HUM_HIGH_RESET  = 10'd1000;
  localparam logic [9:0]         HUM_LOW_RESET   = 10'd0;

  typedef enum logic [1:0] {
    CFG_TEMP_HIGH = 2'd0,
    CFG_TEMP_LOW  = 2'd1,
    CFG_HUM_HIGH  = 2'd2,
    CFG_HUM_LOW   = 2'd3
  } cfg_reg_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    crc = crc_in ^ data;
    for (int i = 0; i < 8; i++) begin
      crc = crc[7] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
    end
    return crc;
  endfunction

  function automatic logic [7:0] crc8_pair(input logic [7:0] b0, input logic [7:0] b1);
    return crc8_byte(crc8_byte(CRC_INIT, b0), b1);
  endfunction

endpackage

[hw/rtl/humidity_temp_frame_checker_filter.sv]
// Checked sensor-frame filter. Each item is one six-byte frame holding a raw
// temperature word and a raw humidity word, each followed by its CRC-8
// (polynomial 0x31, initial value 0xFF). When both CRCs match, the words are
// scaled to tenths of a degree and of a percent with 8 fraction bits, written
// into a circular window of WINDOW_DEPTH entries per quantity, and the window
// means (truncated toward zero) and limit alarms are returned. On a mismatch
// only crc_error is set and the last means and alarms are repeated. The block
// takes one item every cycle while in_stall is low, and each result passes
// through stages A to E and the output register. The rate is set by the
// window memories, which are read in one stage and written back in the next,
// so each slot sees one read-modify-write per item. The window starts at zero
// after reset through one valid bit per entry, so no clearing pass is needed
// and items are taken straight out of reset. Limit registers may be written at
// any time the block is idle; the configuration port is always ready.
module humidity_temp_frame_checker_filter #(
  parameter int WINDOW_DEPTH = htfc_pkg::DEFAULT_WINDOW_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_temp_msb,
  input  logic [7:0]         in_temp_lsb,
  input  logic [7:0]         in_temp_check,
  input  logic [7:0]         in_hum_msb,
  input  logic [7:0]         in_hum_lsb,
  input  logic [7:0]         in_hum_check,

  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [11:0] out_mean_temp,
  output logic [9:0]         out_mean_hum,
  output logic               out_crc_error,
  output logic               out_temp_alarm,
  output logic               out_hum_alarm,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_data
);

  // Widths. The products of a 16-bit raw word and the scale factors stay
  // below 2^35; quotients by 65535 stay below 2^19.
  localparam int SLOT_W   = $clog2(WINDOW_DEPTH);
  localparam int PROD_W   = 35;
  localparam int EST_W    = 36;
  localparam int QEST_W   = EST_W - 16;
  localparam int REM_W    = 37;
  localparam int Q_W      = 19;
  localparam int TS_W     = 20;
  localparam int HS_W     = 18;
  localparam int TSUM_W   = $clog2(WINDOW_DEPTH * htfc_pkg::TEMP_SAMPLE_MAX + 1) + 1;
  localparam int HSUM_W   = $clog2(WINDOW_DEPTH * htfc_pkg::HUM_SAMPLE_MAX + 1);

  // Mean = floor((|sum| >> 8) / WINDOW_DEPTH). The shifted magnitude stays
  // below 2^MAG_W, and the division is a multiply by a rounded-up reciprocal
  // which is exact over that range.
  localparam int MAG_W    = 17;
  localparam int RECIP_SH = MAG_W + $clog2(WINDOW_DEPTH);
  localparam int RECIP_W  = MAG_W + 1;
  localparam longint unsigned RECIP =
    ((64'd1 << RECIP_SH) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
  localparam int MPROD_W  = MAG_W + RECIP_W;
  localparam int TMAG_W   = 11;
  localparam int HMEAN_W  = 10;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);

  // Division of a product by 65535: x/65535 = x/2^16 * (1 + 2^-16 + 2^-32 ...).
  // The estimate is at most one short, which the remainder test corrects.
  function automatic logic [QEST_W-1:0] div_est(input logic [PROD_W-1:0] x);
    logic [EST_W-1:0] acc;
    acc = EST_W'(x) + EST_W'(x >> 16) + EST_W'(x >> 32);
    return acc[EST_W-1:16];
  endfunction

  function automatic logic [Q_W-1:0] div_fix(input logic [PROD_W-1:0] x,
                                             input logic [QEST_W-1:0] q1);
    logic [REM_W-1:0] rem;
    logic [QEST_W-1:0] q;
    rem = REM_W'(x) + REM_W'(q1) - (REM_W'(q1) << 16);
    q   = (rem >= REM_W'(17'd65535)) ? q1 + QEST_W'(1) : q1;
    return Q_W'(q);
  endfunction

  // ---------------------------------------------------------------------
  // Limit registers.
  // ---------------------------------------------------------------------
  logic signed [11:0] temp_high_r, temp_low_r;
  logic [9:0]         hum_high_r, hum_low_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_high_r <= htfc_pkg::TEMP_HIGH_RESET;
      temp_low_r  <= htfc_pkg::TEMP_LOW_RESET;
      hum_high_r  <= htfc_pkg::HUM_HIGH_RESET;
      hum_low_r   <= htfc_pkg::HUM_LOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (htfc_pkg::cfg_reg_t'(cfg_index))
        htfc_pkg::CFG_TEMP_HIGH: temp_high_r <= $signed(cfg_data);
        htfc_pkg::CFG_TEMP_LOW:  temp_low_r  <= $signed(cfg_data);
        htfc_pkg::CFG_HUM_HIGH:  hum_high_r  <= cfg_data[9:0];
        htfc_pkg::CFG_HUM_LOW:   hum_low_r   <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline flow. Each stage holds one item and moves on when the stage
  // after it is empty or moving, so bubbles close up behind a stalled
  // output register.
  // ---------------------------------------------------------------------
  logic a_v_r, b_v_r, c_v_r, d_v_r, e_v_r, out_valid_r;
  logic a_rdy, b_rdy, c_rdy, d_rdy, e_rdy, out_rdy;
  logic mv_in, mv_a, mv_b, mv_c, mv_d, mv_e;

  assign out_rdy = !out_valid_r || !out_stall;
  assign e_rdy   = !e_v_r || out_rdy;
  assign d_rdy   = !d_v_r || e_rdy;
  assign c_rdy   = !c_v_r || d_rdy;
  assign b_rdy   = !b_v_r || c_rdy;
  assign a_rdy   = !a_v_r || b_rdy;

  assign in_stall = !a_rdy;
  assign mv_in    = in_valid && a_rdy;
  assign mv_a     = a_v_r && b_rdy;
  assign mv_b     = b_v_r && c_rdy;
  assign mv_c     = c_v_r && d_rdy;
  assign mv_d     = d_v_r && e_rdy;
  assign mv_e     = e_v_r && out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      d_v_r       <= 1'b0;
      e_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_rdy)   a_v_r       <= in_valid;
      if (b_rdy)   b_v_r       <= a_v_r;
      if (c_rdy)   c_v_r       <= b_v_r;
      if (d_rdy)   d_v_r       <= c_v_r;
      if (e_rdy)   e_v_r       <= d_v_r;
      if (out_rdy) out_valid_r <= e_v_r;
    end
  end

  // ---------------------------------------------------------------------
  // Accept: CRC check, constant multiplies and slot assignment. A frame
  // that fails the check takes no slot.
  // ---------------------------------------------------------------------
  logic              crc_ok;
  logic [15:0]       traw, hraw;
  logic [SLOT_W-1:0] slot_r;

  assign crc_ok = (htfc_pkg::crc8_pair(in_temp_msb, in_temp_lsb) == in_temp_check) &&
                  (htfc_pkg::crc8_pair(in_hum_msb, in_hum_lsb) == in_hum_check);
  assign traw   = {in_temp_msb, in_temp_lsb};
  assign hraw   = {in_hum_msb, in_hum_lsb};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else if (mv_in && crc_ok) begin
      slot_r <= (slot_r == LAST_SLOT) ? '0 : slot_r + SLOT_W'(1);
    end
  end

  logic              a_err_r;
  logic [PROD_W-1:0] a_tprod_r, a_hprod_r;
  logic [SLOT_W-1:0] a_slot_r;

  always_ff @(posedge clk) begin
    if (mv_in) begin
      a_err_r   <= !crc_ok;
      a_tprod_r <= PROD_W'(traw) * PROD_W'(htfc_pkg::TEMP_SCALE);
      a_hprod_r <= PROD_W'(hraw) * PROD_W'(htfc_pkg::HUM_SCALE);
      a_slot_r  <= slot_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage A: quotient estimates, and the read of the old window entries.
  // An entry not yet written since reset reads as zero through its valid
  // bit. The entry that a later item reads was written back by an item at
  // least two places ahead, so the read never overlaps its write.
  // ---------------------------------------------------------------------
  logic [TS_W-1:0]         temp_mem [WINDOW_DEPTH];
  logic [HS_W-1:0]         hum_mem  [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] ent_vld_r;

  logic              b_err_r;
  logic [PROD_W-1:0] b_tprod_r, b_hprod_r;
  logic [QEST_W-1:0] b_tq1_r, b_hq1_r;
  logic [SLOT_W-1:0] b_slot_r;
  logic              b_old_vld_r;
  logic [TS_W-1:0]   b_told_raw_r;
  logic [HS_W-1:0]   b_hold_raw_r;

  always_ff @(posedge clk) begin
    if (mv_a) begin
      b_err_r      <= a_err_r;
      b_tprod_r    <= a_tprod_r;
      b_hprod_r    <= a_hprod_r;
      b_tq1_r      <= div_est(a_tprod_r);
      b_hq1_r      <= div_est(a_hprod_r);
      b_slot_r     <= a_slot_r;
      b_old_vld_r  <= ent_vld_r[a_slot_r];
      b_told_raw_r <= temp_mem[a_slot_r];
      b_hold_raw_r <= hum_mem[a_slot_r];
    end
  end

  // ---------------------------------------------------------------------
  // Stage B: final samples, written back into the window.
  // ---------------------------------------------------------------------
  logic signed [TS_W-1:0] b_ts;
  logic [HS_W-1:0]        b_hs;
  logic                   b_wr;

  assign b_ts = $signed(TS_W'(div_fix(b_tprod_r, b_tq1_r))) - $signed(htfc_pkg::TEMP_OFFSET);
  assign b_hs = HS_W'(div_fix(b_hprod_r, b_hq1_r));
  assign b_wr = mv_b && !b_err_r;

  always_ff @(posedge clk) begin
    if (b_wr) begin
      temp_mem[b_slot_r] <= b_ts;
      hum_mem[b_slot_r]  <= b_hs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
    end else if (b_wr) begin
      ent_vld_r[b_slot_r] <= 1'b1;
    end
  end

  logic                   c_err_r;
  logic signed [TS_W-1:0] c_ts_r, c_told_r;
  logic [HS_W-1:0]        c_hs_r, c_hold_r;

  always_ff @(posedge clk) begin
    if (mv_b) begin
      c_err_r  <= b_err_r;
      c_ts_r   <= b_ts;
      c_hs_r   <= b_hs;
      c_told_r <= b_old_vld_r ? $signed(b_told_raw_r) : '0;
      c_hold_r <= b_old_vld_r ? b_hold_raw_r : '0;
    end
  end

  // ---------------------------------------------------------------------
  // Stage C: running sums, updated as each good item leaves.
  // ---------------------------------------------------------------------
  logic signed [TSUM_W-1:0] tsum_r, tsum_nxt;
  logic [HSUM_W-1:0]        hsum_r, hsum_nxt;

  assign tsum_nxt = tsum_r + TSUM_W'(c_ts_r) - TSUM_W'(c_told_r);
  assign hsum_nxt = hsum_r + HSUM_W'(c_hs_r) - HSUM_W'(c_hold_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsum_r <= '0;
      hsum_r <= '0;
    end else if (mv_c && !c_err_r) begin
      tsum_r <= tsum_nxt;
      hsum_r <= hsum_nxt;
    end
  end

  logic                     d_err_r;
  logic signed [TSUM_W-1:0] d_tsum_r;
  logic [HSUM_W-1:0]        d_hsum_r;

  always_ff @(posedge clk) begin
    if (mv_c) begin
      d_err_r  <= c_err_r;
      d_tsum_r <= tsum_nxt;
      d_hsum_r <= hsum_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage D: magnitude and reciprocal multiply. Truncation toward zero is
  // the floor of the magnitude with the sign put back afterwards.
  // ---------------------------------------------------------------------
  logic              d_tneg;
  logic [TSUM_W-1:0] d_tmag;
  logic [MAG_W-1:0]  d_tmag_sh, d_hmag_sh;

  assign d_tneg    = d_tsum_r[TSUM_W-1];
  assign d_tmag    = d_tneg ? TSUM_W'(-d_tsum_r) : TSUM_W'(d_tsum_r);
  assign d_tmag_sh = MAG_W'(d_tmag >> 8);
  assign d_hmag_sh = MAG_W'(d_hsum_r >> 8);

  logic               e_err_r;
  logic               e_tneg_r;
  logic [MPROD_W-1:0] e_tprod_r, e_hprod_r;

  always_ff @(posedge clk) begin
    if (mv_d) begin
      e_err_r   <= d_err_r;
      e_tneg_r  <= d_tneg;
      e_tprod_r <= MPROD_W'(d_tmag_sh) * MPROD_W'(RECIP_W'(RECIP));
      e_hprod_r <= MPROD_W'(d_hmag_sh) * MPROD_W'(RECIP_W'(RECIP));
    end
  end

  // ---------------------------------------------------------------------
  // Stage E: means and alarms into the output register. A failed frame
  // repeats the held results of the last good frame.
  // ---------------------------------------------------------------------
  logic [TMAG_W-1:0]   e_tq;
  logic signed [11:0]  e_mean_t;
  logic [HMEAN_W-1:0]  e_mean_h;
  logic                e_talm, e_halm;

  assign e_tq     = TMAG_W'(e_tprod_r >> RECIP_SH);
  assign e_mean_t = e_tneg_r ? -$signed({1'b0, e_tq}) : $signed({1'b0, e_tq});
  assign e_mean_h = HMEAN_W'(e_hprod_r >> RECIP_SH);
  assign e_talm   = (e_mean_t > temp_high_r) || (e_mean_t < temp_low_r);
  assign e_halm   = (e_mean_h > hum_high_r) || (e_mean_h < hum_low_r);

  logic signed [11:0] held_mean_t_r;
  logic [9:0]         held_mean_h_r;
  logic               held_talm_r, held_halm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_mean_t_r <= '0;
      held_mean_h_r <= '0;
      held_talm_r   <= 1'b0;
      held_halm_r   <= 1'b0;
    end else if (mv_e && !e_err_r) begin
      held_mean_t_r <= e_mean_t;
      held_mean_h_r <= e_mean_h;
      held_talm_r   <= e_talm;
      held_halm_r   <= e_halm;
    end
  end

  logic signed [11:0] out_mean_t_r;
  logic [9:0]         out_mean_h_r;
  logic               out_err_r, out_talm_r, out_halm_r;

  always_ff @(posedge clk) begin
    if (mv_e) begin
      out_err_r <= e_err_r;
      if (e_err_r) begin
        out_mean_t_r <= held_mean_t_r;
        out_mean_h_r <= held_mean_h_r;
        out_talm_r   <= held_talm_r;
        out_halm_r   <= held_halm_r;
      end else begin
        out_mean_t_r <= e_mean_t;
        out_mean_h_r <= e_mean_h;
        out_talm_r   <= e_talm;
        out_halm_r   <= e_halm;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mean_temp  = out_mean_t_r;
  assign out_mean_hum   = out_mean_h_r;
  assign out_crc_error  = out_err_r;
  assign out_temp_alarm = out_talm_r;
  assign out_hum_alarm  = out_halm_r;

endmodule

[dv/tb_humidity_temp_frame_checker_filter.sv]
// Testbench for the checked sensor-frame filter.
//
// Every item is one six-byte frame: a raw temperature word and a raw humidity
// word, each followed by its CRC-8. Each accepted item is run at once through
// a predictor kept in this module. The predictor checks both CRCs, scales the
// words to tenths with eight fraction bits, updates a circular window and
// running sums, and works out the means and alarms that the block must return.
// The prediction goes on the back of a queue. A separate process takes each
// result that the block hands over, compares it field by field with the front
// of that queue and counts any difference as a failure.
//
// Both channels use valid and stall. Inputs are driven with nonblocking
// assignments at the rising edge. Outputs are sampled at the rising edge, so
// every value that is read is the one that the block saw at that edge.
//
// The limit registers are only written while nothing is in flight. Every item
// gives exactly one result, so an empty queue means the block is idle.
module tb_humidity_temp_frame_checker_filter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     DEPTH          = htfc_pkg::DEFAULT_WINDOW_DEPTH;
  localparam longint RAW_FULL_SCALE = 65535;
  localparam longint MEAN_DIVISOR   = DEPTH * 256;
  // These are the cycles allowed at the end of the run for anything stray
  // to show up.
  localparam int     SETTLE_CYCLES  = 16;
  localparam int     CYCLE_LIMIT    = 250000;
  localparam int     MAX_REPORTS    = 10;

  typedef struct packed {
    logic [7:0] temp_msb;
    logic [7:0] temp_lsb;
    logic [7:0] temp_check;
    logic [7:0] hum_msb;
    logic [7:0] hum_lsb;
    logic [7:0] hum_check;
  } frame_t;

  typedef struct packed {
    logic [11:0] mean_temp;
    logic [9:0]  mean_hum;
    logic        crc_error;
    logic        temp_alarm;
    logic        hum_alarm;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_temp_msb = '0;
  logic [7:0]  in_temp_lsb = '0;
  logic [7:0]  in_temp_check = '0;
  logic [7:0]  in_hum_msb = '0;
  logic [7:0]  in_hum_lsb = '0;
  logic [7:0]  in_hum_check = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [11:0] out_mean_temp;
  logic [9:0]         out_mean_hum;
  logic               out_crc_error;
  logic               out_temp_alarm;
  logic               out_hum_alarm;

  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  htfc_pkg::cfg_reg_t  cfg_index = htfc_pkg::CFG_TEMP_HIGH;
  logic [11:0]         cfg_data = '0;

  humidity_temp_frame_checker_filter #(
    .WINDOW_DEPTH(DEPTH)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_temp_msb   (in_temp_msb),
    .in_temp_lsb   (in_temp_lsb),
    .in_temp_check (in_temp_check),
    .in_hum_msb    (in_hum_msb),
    .in_hum_lsb    (in_hum_lsb),
    .in_hum_check  (in_hum_check),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_mean_temp (out_mean_temp),
    .out_mean_hum  (out_mean_hum),
    .out_crc_error (out_crc_error),
    .out_temp_alarm(out_temp_alarm),
    .out_hum_alarm (out_hum_alarm),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: the window of scaled samples, the running sums, the next
  // slot to be overwritten, the last good means and alarms, and the limits.
  // ---------------------------------------------------------------------------
  longint             temp_window [DEPTH];
  longint             hum_window [DEPTH];
  longint             temp_total;
  longint             hum_total;
  int                 next_slot;
  reading_t           held_reading;
  logic signed [11:0] lim_temp_high;
  logic signed [11:0] lim_temp_low;
  logic [9:0]         lim_hum_high;
  logic [9:0]         lim_hum_low;

  reading_t pending_readings[$];
  int       fail_count = 0;
  int       cycles_run = 0;

  // Receiver controls. The test asks for a long hold-off by setting its
  // length and toggling the request bit. The receiver counts it down itself.
  int stall_pct = 0;
  int hold_off_len = 0;
  bit hold_off_req = 1'b0;
  bit hold_off_ack = 1'b0;
  int hold_off_left = 0;

  // The CRC is worked bit by bit over the 16-bit word, MSB first. The result
  // is the same as the usual byte-wise form.
  function automatic logic [7:0] frame_crc8(input logic [15:0] word);
    logic [7:0] crc;
    logic       feedback;
    crc = htfc_pkg::CRC_INIT;
    for (int i = 15; i >= 0; i--) begin
      feedback = crc[7] ^ word[i];
      crc = {crc[6:0], 1'b0};
      if (feedback) crc = crc ^ htfc_pkg::CRC_POLY;
    end
    return crc;
  endfunction

  function automatic void reset_predictor();
    for (int i = 0; i < DEPTH; i++) begin
      temp_window[i] = 0;
      hum_window[i] = 0;
    end
    temp_total = 0;
    hum_total = 0;
    next_slot = 0;
    held_reading = '0;
    lim_temp_high = htfc_pkg::TEMP_HIGH_RESET;
    lim_temp_low = htfc_pkg::TEMP_LOW_RESET;
    lim_hum_high = htfc_pkg::HUM_HIGH_RESET;
    lim_hum_low = htfc_pkg::HUM_LOW_RESET;
  endfunction

  // The humidity limits keep only the low ten bits of the written data.
  function automatic void apply_limit(input htfc_pkg::cfg_reg_t idx, input logic [11:0] data);
    case (idx)
      htfc_pkg::CFG_TEMP_HIGH: lim_temp_high = data;
      htfc_pkg::CFG_TEMP_LOW:  lim_temp_low = data;
      htfc_pkg::CFG_HUM_HIGH:  lim_hum_high = data[9:0];
      htfc_pkg::CFG_HUM_LOW:   lim_hum_low = data[9:0];
      default: ;
    endcase
  endfunction

  // Takes one frame and returns the result that the block must give for it.
  // A good frame moves the window on. A bad one repeats the held values and
  // sets the error flag.
  function automatic reading_t predict_reading(input frame_t f);
    longint   t_raw;
    longint   h_raw;
    longint   t_sample;
    longint   h_sample;
    longint   t_mean;
    longint   h_mean;
    reading_t r;
    if (frame_crc8({f.temp_msb, f.temp_lsb}) == f.temp_check &&
        frame_crc8({f.hum_msb, f.hum_lsb}) == f.hum_check) begin
      t_raw = longint'({f.temp_msb, f.temp_lsb});
      h_raw = longint'({f.hum_msb, f.hum_lsb});
      t_sample = (longint'(htfc_pkg::TEMP_SCALE) * t_raw) / RAW_FULL_SCALE -
                 longint'(htfc_pkg::TEMP_OFFSET);
      h_sample = (longint'(htfc_pkg::HUM_SCALE) * h_raw) / RAW_FULL_SCALE;
      temp_total += t_sample - temp_window[next_slot];
      hum_total += h_sample - hum_window[next_slot];
      temp_window[next_slot] = t_sample;
      hum_window[next_slot] = h_sample;
      next_slot = (next_slot == DEPTH - 1) ? 0 : next_slot + 1;
      // Signed division truncates toward zero, as the means require.
      t_mean = temp_total / MEAN_DIVISOR;
      h_mean = hum_total / MEAN_DIVISOR;
      held_reading.mean_temp = t_mean[11:0];
      held_reading.mean_hum = h_mean[9:0];
      held_reading.temp_alarm = (t_mean > lim_temp_high) || (t_mean < lim_temp_low);
      held_reading.hum_alarm = (h_mean > longint'(lim_hum_high)) ||
                               (h_mean < longint'(lim_hum_low));
      r = held_reading;
    end else begin
      r = held_reading;
      r.crc_error = 1'b1;
    end
    return r;
  endfunction

  function automatic frame_t build_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
                                         input bit t_bad, input bit h_bad);
    frame_t f;
    f.temp_msb = t_raw[15:8];
    f.temp_lsb = t_raw[7:0];
    f.hum_msb = h_raw[15:8];
    f.hum_lsb = h_raw[7:0];
    f.temp_check = frame_crc8(t_raw) ^ (t_bad ? 8'($urandom_range(255, 1)) : 8'h00);
    f.hum_check = frame_crc8(h_raw) ^ (h_bad ? 8'($urandom_range(255, 1)) : 8'h00);
    return f;
  endfunction

  // Raw words are spread evenly, pinned at the extremes, or kept close to a
  // level that changes from burst to burst. The level lets the means drift
  // right across their range, so both alarm limits get crossed.
  function automatic logic [15:0] pick_raw(input logic [15:0] level);
    int sel;
    int v;
    sel = $urandom_range(9, 0);
    if (sel < 4) return 16'($urandom);
    if (sel == 4) return ($urandom_range(1, 0) != 0) ? 16'hFFFF : 16'h0000;
    v = int'(level) + int'($urandom_range(3000, 0)) - 1500;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Shared driving tasks.
  // ---------------------------------------------------------------------------

  // Offers one item and holds it until the block takes it. Valid stays high
  // on return, so the next item can follow with no gap.
  task automatic send_frame(input frame_t f);
    in_valid <= 1'b1;
    in_temp_msb <= f.temp_msb;
    in_temp_lsb <= f.temp_lsb;
    in_temp_check <= f.temp_check;
    in_hum_msb <= f.hum_msb;
    in_hum_lsb <= f.hum_lsb;
    in_hum_check <= f.hum_check;
    do @(posedge clk); while (in_stall);
    pending_readings.push_back(predict_reading(f));
  endtask

  task automatic idle_input(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // The sender stops and waits until every expected result has come back.
  task automatic wait_drained();
    idle_input(1);
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  // Writes one register. Valid is left high so that writes can follow back
  // to back. The caller lowers it.
  task automatic write_limit(input htfc_pkg::cfg_reg_t idx, input logic [11:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_limit(idx, data);
  endtask

  task automatic configure_limits(input logic [11:0] t_high, input logic [11:0] t_low,
                                  input logic [11:0] h_high, input logic [11:0] h_low);
    write_limit(htfc_pkg::CFG_TEMP_HIGH, t_high);
    write_limit(htfc_pkg::CFG_TEMP_LOW, t_low);
    write_limit(htfc_pkg::CFG_HUM_HIGH, h_high);
    write_limit(htfc_pkg::CFG_HUM_LOW, h_low);
    cfg_valid <= 1'b0;
  endtask

  // Sends items in bursts of random length, with a random gap after each
  // burst. A gap_max of zero gives one continuous stream.
  task automatic stream_frames(input int count, input int gap_max, input int bad_pct);
    int         sent;
    int         burst;
    int         kind;
    logic [15:0] t_level;
    logic [15:0] h_level;
    bit         t_bad;
    bit         h_bad;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(24, 1);
      t_level = 16'($urandom);
      h_level = 16'($urandom);
      for (int i = 0; i < burst && sent < count; i++) begin
        t_bad = 1'b0;
        h_bad = 1'b0;
        if ($urandom_range(99, 0) < bad_pct) begin
          kind = $urandom_range(2, 0);
          t_bad = (kind != 1);
          h_bad = (kind != 0);
        end
        send_frame(build_frame(pick_raw(t_level), pick_raw(h_level), t_bad, h_bad));
        sent++;
      end
      if (gap_max > 0) idle_input($urandom_range(gap_max, 1));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // This runs straight out of reset with the limits at their reset values.
  // Bad frames come first, so the held zeros are seen. Then both extremes of
  // the raw words are repeated long enough to fill and wrap the window. The
  // early frames take the zero entries into the mean, and full-scale frames
  // push the temperature mean above its upper limit. A run of all-zero frames
  // then pulls it below the lower limit. Bad frames at the end must repeat
  // the held alarms.
  task automatic test_extremes_and_crc();
    send_frame(build_frame(16'h1234, 16'h5678, 1'b1, 1'b0));
    send_frame(build_frame(16'h1234, 16'h5678, 1'b0, 1'b1));
    idle_input(2);
    send_frame(build_frame(16'hFFFF, 16'h0000, 1'b1, 1'b1));
    send_frame(build_frame(16'h0000, 16'h0000, 1'b0, 1'b0));
    for (int i = 0; i < 9; i++) begin
      send_frame(build_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
      if (i == 4) idle_input(3);
    end
    for (int i = 0; i < 9; i++) send_frame(build_frame(16'h0000, 16'h0000, 1'b0, 1'b0));
    send_frame(build_frame(16'h00FF, 16'hFF00, 1'b1, 1'b0));
    send_frame(build_frame(16'hFF00, 16'h00FF, 1'b0, 1'b1));
    wait_drained();
  endtask

  // Several limit settings in turn. The first is the widest legal range. In
  // the second the limits are crossed, with low above high, so every mean is
  // in alarm. The third uses the signed extremes of the register, and the
  // humidity data has its upper bits set, which the block must drop. The last
  // is a narrow band in the middle.
  task automatic test_limit_settings();
    stall_pct = 25;
    configure_limits(12'(1300), -12'sd450, 12'(1000), 12'(0));
    stream_frames(40, 6, 10);
    wait_drained();
    configure_limits(-12'sd450, 12'(1300), 12'(0), 12'(1000));
    stream_frames(40, 6, 10);
    wait_drained();
    configure_limits(12'h7FF, 12'h800, 12'hFFF, 12'hC00);
    stream_frames(40, 6, 10);
    wait_drained();
    configure_limits(12'(600), 12'(250), 12'(700), 12'(300));
    stream_frames(40, 6, 10);
    wait_drained();
  endtask

  // This is the bulk of the random traffic. Each phase draws fresh limits,
  // crossed now and then, together with its own stall rate and gap length.
  // Some phases send with no gaps between bursts.
  task automatic test_random_traffic();
    int a;
    int b;
    int c;
    int d;
    int gap_max;
    for (int phase = 0; phase < 8; phase++) begin
      a = int'($urandom_range(1750, 0)) - 450;
      b = int'($urandom_range(1750, 0)) - 450;
      c = $urandom_range(1000, 0);
      d = $urandom_range(1000, 0);
      if ($urandom_range(5, 0) == 0)
        configure_limits(12'((a < b) ? a : b), 12'((a < b) ? b : a), 12'(c), 12'(d));
      else
        configure_limits(12'((a < b) ? b : a), 12'((a < b) ? a : b),
                         12'((c < d) ? d : c), 12'((c < d) ? c : d));
      case ($urandom_range(3, 0))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 75;
      endcase
      gap_max = (phase % 3 == 0) ? 0 : $urandom_range(12, 2);
      stream_frames(165, gap_max, 15);
      wait_drained();
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // items with no gap, so the block fills up and stalls its input. The sender
  // then pauses until every result is back before a final stretch of traffic.
  task automatic test_backpressure();
    stall_pct = 0;
    hold_off_len = 200;
    hold_off_req = ~hold_off_req;
    stream_frames(60, 0, 10);
    wait_drained();
    stall_pct = 50;
    stream_frames(40, 8, 10);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: a random stall pattern, or a long hold-off when one is asked for.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off_req != hold_off_ack) begin
      hold_off_ack <= hold_off_req;
      hold_off_left <= hold_off_len;
      out_stall <= 1'b1;
    end else if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    reading_t got;
    reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{mean_temp: out_mean_temp, mean_hum: out_mean_hum, crc_error: out_crc_error,
              temp_alarm: out_temp_alarm, hum_alarm: out_hum_alarm};
      if (pending_readings.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result at cycle %0d: temp %0d hum %0d err %0b alarms %0b%0b",
                   cycles_run, $signed(got.mean_temp), got.mean_hum, got.crc_error,
                   got.temp_alarm, got.hum_alarm);
      end else begin
        want = pending_readings.pop_front();
        if (got.mean_temp !== want.mean_temp || got.mean_hum !== want.mean_hum ||
            got.crc_error !== want.crc_error || got.temp_alarm !== want.temp_alarm ||
            got.hum_alarm !== want.hum_alarm) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("mismatch at cycle %0d: expected temp %0d hum %0d err %0b alarms %0b%0b,",
                     cycles_run, $signed(want.mean_temp), want.mean_hum, want.crc_error,
                     want.temp_alarm, want.hum_alarm,
                     " got temp %0d hum %0d err %0b alarms %0b%0b",
                     $signed(got.mean_temp), got.mean_hum,
                     got.crc_error, got.temp_alarm, got.hum_alarm);
        end
      end
    end
  end

  // The whole run is bounded. A hang anywhere ends it as a failure.
  always @(posedge clk) begin
    cycles_run <= cycles_run + 1;
    if (cycles_run >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles_run);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    reset_predictor();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes_and_crc();
    test_limit_settings();
    test_random_traffic();
    test_backpressure();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_readings.size() != 0) begin
      $display("%0d expected results never arrived", pending_readings.size());
      fail_count += pending_readings.size();
    end
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d failures", fail_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
